### hw/rtl/value_sorted_key_list_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the value sorted key list.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef VALUE_SORTED_KEY_LIST_MACROS_SVH
`define VALUE_SORTED_KEY_LIST_MACROS_SVH

`ifndef SYNTH

// Whenever the condition holds, the consequence holds in the same cycle.
`define VSKL_ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("value_sorted_key_list: same-cycle check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define VSKL_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("value_sorted_key_list: next-cycle check failed");

`else

`define VSKL_ASSERT_IMPLIES(label, clk, rst_n, cond, cons)

`define VSKL_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

### hw/rtl/vskl_pkg.sv
// ----------------------------------------------------------------------------
// vskl_pkg
// Shared widths, codes and cell control types of the value sorted key list.
// ----------------------------------------------------------------------------
`default_nettype none

package vskl_pkg;

	// Default sizing of the block.
	localparam int KEY_COUNT_DEF  = 256;
	localparam int LIST_DEPTH_DEF = 64;
	localparam int VALUE_BITS_DEF = 32;

	// Fixed field widths of the request and result.
	localparam int FUNC_W   = 3;
	localparam int KEY_W    = 8;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;

	// Function codes of a request.
	localparam logic [FUNC_W-1:0] FUNC_GET_VALUE  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPEND     = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FIND_POS   = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_KEY_AT_POS = 3'd5;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// Operation broadcast to every cell of the list.
	typedef enum logic [2:0] {
		CELL_IDLE,
		CELL_FIND,
		CELL_INSERT,
		CELL_APPEND,
		CELL_REMOVE
	} cell_op_t;

	// Control bundle sent from the sequencer to the cells.
	typedef struct packed {
		cell_op_t op;
		logic     val_write;
	} cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/vskl_ram.sv
// ----------------------------------------------------------------------------
// vskl_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vskl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/vskl_cell.sv
// ----------------------------------------------------------------------------
// vskl_cell
// One slot of the ordered key list. It holds a key and that key's current
// value, compares them against the broadcast request and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module vskl_cell #(
	parameter int KW         = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vskl_pkg::cell_ctl_t          ctl,
	input  logic [KW-1:0]                req_key,
	input  logic signed [VALUE_BITS-1:0] req_val,
	input  logic                         left_valid,
	input  logic [KW-1:0]                left_key,
	input  logic signed [VALUE_BITS-1:0] left_val,
	input  logic                         right_valid,
	input  logic [KW-1:0]                right_key,
	input  logic signed [VALUE_BITS-1:0] right_val,
	input  logic                         hit_in,
	output logic                         valid,
	output logic [KW-1:0]                key,
	output logic signed [VALUE_BITS-1:0] val,
	output logic                         hit_out,
	output logic                         first
);

	import vskl_pkg::*;

	logic                         valid_q;
	logic [KW-1:0]                key_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic                         key_match;
	logic                         cond;
	logic                         valid_d;
	logic [KW-1:0]                key_d;
	logic signed [VALUE_BITS-1:0] val_d;

	// An insert stops at the first entry whose value is at most the new one;
	// an entry of the same key already carries the new value, so it stops too.
	assign key_match = valid_q && (key_q == req_key);
	assign cond      = (ctl.op == CELL_INSERT) ? (key_match || (valid_q && (val_q <= req_val)))
	                                           : key_match;
	assign hit_out   = hit_in || cond;
	assign first     = cond && !hit_in;

	// Next contents of the slot.
	always_comb begin
		valid_d = valid_q;
		key_d   = key_q;
		val_d   = val_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (!hit_in && (cond || (!valid_q && left_valid))) begin
					valid_d = 1'b1;
					key_d   = req_key;
					val_d   = req_val;
				end else if (hit_in) begin
					valid_d = left_valid;
					key_d   = left_key;
					val_d   = left_val;
				end
			end
			CELL_APPEND: begin
				if (!valid_q && left_valid) begin
					valid_d = 1'b1;
					key_d   = req_key;
					val_d   = req_val;
				end
			end
			CELL_REMOVE: begin
				if (hit_in || cond) begin
					valid_d = right_valid;
					key_d   = right_key;
					val_d   = right_val;
				end
			end
			default: begin
			end
		endcase
		// Every copy of the written key follows the value store.
		if (ctl.val_write && (key_d == req_key)) begin
			val_d = req_val;
		end
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Slot payload.
	always_ff @(posedge clk) begin
		key_q <= key_d;
		val_q <= val_d;
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign val   = val_q;

endmodule

`default_nettype wire

### hw/rtl/value_sorted_key_list.sv
// A result is loaded into the result register from S_EXEC, for update from S_PLACE
// after S_EXEC, once the output slot is free; a new request is taken only in S_IDLE,
// after the last one is done. The list is a row of LIST_DEPTH cells that search and
// shift together, and update needs two passes. Reset: the list empties at once, then
// the value store is cleared one entry per cycle through its write port, with in_ready low.
// ----------------------------------------------------------------------------
// value_sorted_key_list
// Per-key value store plus a list of keys, placed by value, highest first, on insert
// and at the tail on append, built as a chain of cells driven by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "value_sorted_key_list_macros.svh"

module value_sorted_key_list #(
	parameter int KEY_COUNT  = vskl_pkg::KEY_COUNT_DEF,
	parameter int LIST_DEPTH = vskl_pkg::LIST_DEPTH_DEF,
	parameter int VALUE_BITS = vskl_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [vskl_pkg::FUNC_W-1:0]          func,
	input  logic [vskl_pkg::KEY_W-1:0]           key,
	input  logic signed [vskl_pkg::VAL_W-1:0]    value,
	input  logic [vskl_pkg::POS_W-1:0]           position,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [vskl_pkg::POS_W-1:0]           position_out,
	output logic [vskl_pkg::KEY_W-1:0]           key_out,
	output logic signed [vskl_pkg::VAL_W-1:0]    value_out,
	output logic [vskl_pkg::STATUS_W-1:0]        status
);

	import vskl_pkg::*;

	localparam int KW = $clog2(KEY_COUNT);
	localparam int PW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_PLACE
	} state_t;

	state_t                       state_q;
	logic [KW-1:0]                clr_q;
	logic [CW-1:0]                count_q;
	logic [FUNC_W-1:0]            func_q;
	logic [KW-1:0]                key_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]             pos_q;
	logic                         out_valid_q;
	logic [POS_W-1:0]             pos_out_q;
	logic [KEY_W-1:0]             key_out_q;
	logic signed [VAL_W-1:0]      val_out_q;
	logic [STATUS_W-1:0]          status_q;

	logic [KEY_W-1:0]             key_rem;
	logic [KW-1:0]                key_in;
	logic signed [VALUE_BITS-1:0] val_in;
	logic [VALUE_BITS-1:0]        ram_rdata;
	logic signed [VAL_W-1:0]      rd_val;
	logic                         ram_we;
	logic [KW-1:0]                ram_waddr;
	logic [VALUE_BITS-1:0]        ram_wdata;
	logic [KW-1:0]                ram_raddr;

	logic                         slot_free;
	logic                         res_load;
	logic                         full;
	logic                         found;
	logic [PW-1:0]                hit_idx;
	logic [KW-1:0]                keypos;
	logic [CW-1:0]                place_idx;
	cell_ctl_t                    ctl;
	logic                         op_we;
	logic                         go_place;
	logic                         cnt_inc;
	logic                         cnt_dec;
	logic [POS_W-1:0]             res_pos;
	logic [KEY_W-1:0]             res_key;
	logic signed [VAL_W-1:0]      res_val;
	logic [STATUS_W-1:0]          res_status;

	logic [LIST_DEPTH-1:0]        c_valid;
	logic [KW-1:0]                c_key [LIST_DEPTH];
	logic signed [VALUE_BITS-1:0] c_val [LIST_DEPTH];
	logic [LIST_DEPTH:0]          c_hit;
	logic [LIST_DEPTH-1:0]        c_first;

	// Key reduced modulo KEY_COUNT by restoring long division.
	always_comb begin
		key_rem = key;
		for (int s = KEY_W - 1; s >= 0; s--) begin
			if (32'(key_rem) >= (32'(KEY_COUNT) << s)) begin
				key_rem = key_rem - KEY_W'(32'(KEY_COUNT) << s);
			end
		end
		key_in = KW'(key_rem);
	end

	// Input value brought to the stored width, saturating when narrower.
	generate
		if (VALUE_BITS >= VAL_W) begin : g_val_wide
			assign val_in = VALUE_BITS'(value);
			assign rd_val = ram_rdata[VAL_W-1:0];
		end else begin : g_val_narrow
			localparam logic signed [VAL_W-1:0] SAT_HI =
				VAL_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
			localparam logic signed [VAL_W-1:0] SAT_LO = -SAT_HI - VAL_W'(1);
			logic signed [VAL_W-1:0] val_sat;
			always_comb begin
				if (value > SAT_HI) begin
					val_sat = SAT_HI;
				end else if (value < SAT_LO) begin
					val_sat = SAT_LO;
				end else begin
					val_sat = value;
				end
			end
			assign val_in = VALUE_BITS'(val_sat);
			assign rd_val = VAL_W'($signed(ram_rdata));
		end
	endgenerate

	// Value store; the read address holds the request's key while it is served.
	assign ram_raddr = (state_q == S_IDLE) ? key_in : key_q;
	assign ram_we    = (state_q == S_CLEAR) || op_we;
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : key_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : val_q;

	vskl_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(KEY_COUNT)
	) u_value_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Chain of list cells, position 0 on the left.
	assign c_hit[0] = 1'b0;

	generate
		for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
			logic                         l_valid;
			logic [KW-1:0]                l_key;
			logic signed [VALUE_BITS-1:0] l_val;
			logic                         r_valid;
			logic [KW-1:0]                r_key;
			logic signed [VALUE_BITS-1:0] r_val;

			if (i == 0) begin : g_head
				assign l_valid = 1'b1;
				assign l_key   = '0;
				assign l_val   = '0;
			end else begin : g_body
				assign l_valid = c_valid[i-1];
				assign l_key   = c_key[i-1];
				assign l_val   = c_val[i-1];
			end

			if (i == LIST_DEPTH - 1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_key   = '0;
				assign r_val   = '0;
			end else begin : g_inner
				assign r_valid = c_valid[i+1];
				assign r_key   = c_key[i+1];
				assign r_val   = c_val[i+1];
			end

			vskl_cell #(
				.KW(KW),
				.VALUE_BITS(VALUE_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.req_key    (key_q),
				.req_val    (val_q),
				.left_valid (l_valid),
				.left_key   (l_key),
				.left_val   (l_val),
				.right_valid(r_valid),
				.right_key  (r_key),
				.right_val  (r_val),
				.hit_in     (c_hit[i]),
				.valid      (c_valid[i]),
				.key        (c_key[i]),
				.val        (c_val[i]),
				.hit_out    (c_hit[i+1]),
				.first      (c_first[i])
			);
		end
	endgenerate

	// Position of the first hit and the key at the requested position.
	always_comb begin
		hit_idx = '0;
		keypos  = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (c_first[i]) begin
				hit_idx = hit_idx | PW'(i);
			end
			if (int'(pos_q) == i) begin
				keypos = c_key[i];
			end
		end
	end

	assign found     = c_hit[LIST_DEPTH];
	assign full      = (count_q == CW'(LIST_DEPTH));
	assign place_idx = found ? CW'(hit_idx) : count_q;
	assign slot_free = !out_valid_q || out_ready;
	assign res_load  = ((state_q == S_EXEC) || (state_q == S_PLACE)) && slot_free && !go_place;

	// Operation decode and result of the current step.
	always_comb begin
		ctl        = '{op: CELL_IDLE, val_write: 1'b0};
		op_we      = 1'b0;
		go_place   = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		res_pos    = '0;
		res_key    = '0;
		res_val    = '0;
		res_status = STATUS_OK;
		if (state_q == S_EXEC) begin
			unique case (func_q)
				FUNC_GET_VALUE: begin
					res_val = rd_val;
				end
				FUNC_INSERT: begin
					if (full) begin
						res_status = STATUS_FULL;
					end else begin
						ctl     = '{op: CELL_INSERT, val_write: 1'b1};
						op_we   = 1'b1;
						cnt_inc = 1'b1;
						res_pos = POS_W'(place_idx);
					end
				end
				FUNC_APPEND: begin
					if (full) begin
						res_status = STATUS_FULL;
					end else begin
						ctl     = '{op: CELL_APPEND, val_write: 1'b1};
						op_we   = 1'b1;
						cnt_inc = 1'b1;
						res_pos = POS_W'(count_q);
					end
				end
				FUNC_UPDATE: begin
					ctl = '{op: CELL_REMOVE, val_write: 1'b0};
					if (found) begin
						go_place = 1'b1;
						cnt_dec  = 1'b1;
					end else begin
						res_status = STATUS_MISS;
					end
				end
				FUNC_FIND_POS: begin
					ctl = '{op: CELL_FIND, val_write: 1'b0};
					if (found) begin
						res_pos = POS_W'(hit_idx);
					end else begin
						res_status = STATUS_MISS;
					end
				end
				FUNC_KEY_AT_POS: begin
					if ((CW + POS_W)'(pos_q) < (CW + POS_W)'(count_q)) begin
						res_key = KEY_W'(keypos);
					end else begin
						res_status = STATUS_MISS;
					end
				end
				default: begin
					res_status = STATUS_MISS;
				end
			endcase
		end else if (state_q == S_PLACE) begin
			// Second pass of update: the key is gone, insert it again.
			ctl     = '{op: CELL_INSERT, val_write: 1'b1};
			op_we   = 1'b1;
			cnt_inc = 1'b1;
			res_pos = POS_W'(place_idx);
		end
		// Nothing moves while the previous result still waits.
		if (!slot_free) begin
			ctl   = '{op: CELL_IDLE, val_write: 1'b0};
			op_we = 1'b0;
		end
	end

	// Sequencer, request registers, entry count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			func_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			pos_out_q   <= '0;
			key_out_q   <= '0;
			val_out_q   <= '0;
			status_q    <= STATUS_OK;
		end else begin
			// A taken result empties the register unless a new one loads it now.
			if (out_valid_q && out_ready && !res_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + KW'(1);
					if (clr_q == KW'(KEY_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						key_q   <= key_in;
						val_q   <= val_in;
						pos_q   <= position;
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_PLACE: begin
					if (slot_free) begin
						if (cnt_inc) begin
							count_q <= count_q + CW'(1);
						end else if (cnt_dec) begin
							count_q <= count_q - CW'(1);
						end
						if (go_place) begin
							state_q <= S_PLACE;
						end else begin
							out_valid_q <= 1'b1;
							pos_out_q   <= res_pos;
							key_out_q   <= res_key;
							val_out_q   <= res_val;
							status_q    <= res_status;
							state_q     <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign position_out = pos_out_q;
	assign key_out      = key_out_q;
	assign value_out    = val_out_q;
	assign status       = status_q;

	// The list never holds more entries than it has cells.
	`VSKL_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(LIST_DEPTH))

	// Occupied cells and the entry count agree at every edge.
	`VSKL_ASSERT_IMPLIES(a_cells_match_count, clk, arst_n, 1'b1, $countones(c_valid) == int'(count_q))

	// A full status is reported only while the list is full.
	`VSKL_ASSERT_IMPLIES(a_full_status, clk, arst_n, out_valid_q && (status_q == STATUS_FULL), full)

	// Only one request is in flight at a time.
	`VSKL_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for value_sorted_key_list
// Drives a table of directed requests and then random requests in three
// phases of sender and receiver idling. Each result is compared with its row's own
// result or with an in-bench model of the value store and the value-ordered key list.
// ----------------------------------------------------------------------------

module testbench;
	import vskl_pkg::*;

	// Sizing of the block under test and of the run.
	localparam int KEY_COUNT        = KEY_COUNT_DEF;
	localparam int LIST_DEPTH       = LIST_DEPTH_DEF;
	localparam int RANDOM_PER_PHASE = 460;
	localparam int MAX_GAP          = 20;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int DRAIN_CYCLES     = 8;
	localparam int CYCLE_LIMIT      = 250000;

	// Function codes that the block treats as invalid.
	localparam logic [FUNC_W-1:0] FUNC_RESERVED_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_RESERVED_7 = 3'd7;

	// Q16.16 extremes.
	localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VALUE_MIN = 32'sh8000_0000;

	typedef struct {
		logic [FUNC_W-1:0]       func;
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} request_t;

	typedef struct {
		logic [POS_W-1:0]        position_out;
		logic [KEY_W-1:0]        key_out;
		logic signed [VAL_W-1:0] value_out;
		logic [STATUS_W-1:0]     status;
	} result_t;

	typedef struct {
		request_t req;
		bit       typed;
		result_t  want;
	} directed_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [FUNC_W-1:0]       func;
	logic [KEY_W-1:0]        key;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;
	logic                    out_valid;
	logic                    out_ready;
	logic [POS_W-1:0]        position_out;
	logic [KEY_W-1:0]        key_out;
	logic signed [VAL_W-1:0] value_out;
	logic [STATUS_W-1:0]     status;

	// Model state: per-key values and the ordered key list.
	logic signed [VAL_W-1:0] stored_value [KEY_COUNT];
	logic [KEY_W-1:0]        sorted_keys [LIST_DEPTH];
	int                      list_len;
	int                      peak_len;

	result_t       awaited_results [$];
	directed_row_t directed_rows [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_off_req;
	int  error_count;
	int  results_checked;
	int  full_results;
	int  miss_results;
	int  cycle_count;
	int  func_seen [8];
	result_t oldest;

	value_sorted_key_list DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.key          (key),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position_out (position_out),
		.key_out      (key_out),
		.value_out    (value_out),
		.status       (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Returns the first list slot that holds k, or list_len if k is absent.
	function automatic int first_slot(input logic [KEY_W-1:0] k);
		for (int i = 0; i < list_len; i++) begin
			if (sorted_keys[i] == k)
				return i;
		end
		return list_len;
	endfunction

	// Places k ahead of the first entry whose value is at most v.
	function automatic int place_sorted(input logic [KEY_W-1:0] k,
		input logic signed [VAL_W-1:0] v);
		int slot;
		slot = list_len;
		for (int i = 0; i < list_len; i++) begin
			if (stored_value[sorted_keys[i]] <= v) begin
				slot = i;
				break;
			end
		end
		for (int j = list_len; j > slot; j--)
			sorted_keys[j] = sorted_keys[j - 1];
		sorted_keys[slot] = k;
		list_len++;
		return slot;
	endfunction

	// Carries out one request on the model and returns its result.
	function automatic result_t list_operation(input request_t r);
		result_t res;
		int slot;
		res.position_out = '0;
		res.key_out      = '0;
		res.value_out    = '0;
		res.status       = STATUS_OK;
		case (r.func)
			FUNC_GET_VALUE: begin
				res.value_out = stored_value[r.key];
			end
			FUNC_INSERT, FUNC_APPEND: begin
				if (list_len >= LIST_DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					stored_value[r.key] = r.value;
					if (r.func == FUNC_INSERT) begin
						slot = place_sorted(r.key, r.value);
					end else begin
						slot = list_len;
						sorted_keys[slot] = r.key;
						list_len++;
					end
					res.position_out = POS_W'(slot);
				end
			end
			FUNC_UPDATE: begin
				slot = first_slot(r.key);
				if (slot >= list_len) begin
					res.status = STATUS_MISS;
				end else begin
					stored_value[r.key] = r.value;
					for (int i = slot; i + 1 < list_len; i++)
						sorted_keys[i] = sorted_keys[i + 1];
					list_len--;
					res.position_out = POS_W'(place_sorted(r.key, r.value));
				end
			end
			FUNC_FIND_POS: begin
				slot = first_slot(r.key);
				if (slot >= list_len)
					res.status = STATUS_MISS;
				else
					res.position_out = POS_W'(slot);
			end
			FUNC_KEY_AT_POS: begin
				if (int'(r.position) >= list_len)
					res.status = STATUS_MISS;
				else
					res.key_out = sorted_keys[r.position];
			end
			default: begin
				res.status = STATUS_MISS;
			end
		endcase
		if (list_len > peak_len)
			peak_len = list_len;
		return res;
	endfunction

	// Adds one row to the directed table; typed rows carry their own result.
	function automatic void add_row(input logic [FUNC_W-1:0] f,
		input logic [KEY_W-1:0] k, input logic signed [VAL_W-1:0] v,
		input logic [POS_W-1:0] p, input bit typed,
		input logic [POS_W-1:0] want_pos, input logic [KEY_W-1:0] want_key,
		input logic signed [VAL_W-1:0] want_val, input logic [STATUS_W-1:0] want_st);
		directed_row_t row;
		row.req.func          = f;
		row.req.key           = k;
		row.req.value         = v;
		row.req.position      = p;
		row.typed             = typed;
		row.want.position_out = want_pos;
		row.want.key_out      = want_key;
		row.want.value_out    = want_val;
		row.want.status       = want_st;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Random request, biased toward keys, values and positions already in the list.
	function automatic request_t random_request();
		request_t r;
		int pick;
		int units;
		pick = $urandom_range(99);
		if (pick < 12)
			r.func = FUNC_GET_VALUE;
		else if (pick < 30)
			r.func = FUNC_INSERT;
		else if (pick < 38)
			r.func = FUNC_APPEND;
		else if (pick < 63)
			r.func = FUNC_UPDATE;
		else if (pick < 78)
			r.func = FUNC_FIND_POS;
		else if (pick < 95)
			r.func = FUNC_KEY_AT_POS;
		else
			r.func = $urandom_range(1) ? FUNC_RESERVED_7 : FUNC_RESERVED_6;

		if (list_len > 0 && $urandom_range(3) != 0)
			r.key = sorted_keys[$urandom_range(list_len - 1)];
		else
			r.key = KEY_W'($urandom_range(KEY_COUNT - 1));

		case ($urandom_range(3))
			0: begin
				r.value = $urandom;
			end
			1: begin
				units = int'($urandom_range(6)) - 3;
				r.value = units * 65536;
			end
			2: begin
				case ($urandom_range(3))
					0: r.value = VALUE_MAX;
					1: r.value = VALUE_MIN;
					2: r.value = '0;
					default: r.value = -1;
				endcase
			end
			default: begin
				if (list_len > 0)
					r.value = stored_value[sorted_keys[$urandom_range(list_len - 1)]];
				else
					r.value = $urandom;
			end
		endcase

		if (list_len > 0 && $urandom_range(2) != 0)
			r.position = POS_W'($urandom_range(list_len - 1));
		else
			r.position = POS_W'($urandom_range(63));
		return r;
	endfunction

	// Offers one request after a random gap and records its result once accepted.
	task automatic offer_request(input request_t r, input bit typed, input result_t want);
		int gap;
		result_t predicted;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= r.func;
		key      <= r.key;
		value    <= r.value;
		position <= r.position;
		do @(posedge clk); while (!in_ready);
		predicted = list_operation(r);
		awaited_results.insert(awaited_results.size(), typed ? want : predicted);
		func_seen[r.func]++;
	endtask

	// Lowers valid and waits until every awaited result has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checker against the oldest awaited result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none awaited, actual pos %h key %h value %h status %h",
					$time, position_out, key_out, value_out, status);
				error_count++;
			end else begin
				oldest = awaited_results.pop_front();
				check_field("position_out", 32'(oldest.position_out), 32'(position_out));
				check_field("key_out", 32'(oldest.key_out), 32'(key_out));
				check_field("value_out", oldest.value_out, value_out);
				check_field("status", 32'(oldest.status), 32'(status));
				if (oldest.status == STATUS_FULL)
					full_results++;
				if (oldest.status == STATUS_MISS)
					miss_results++;
				results_checked++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Main sequence: reset, directed table, three random phases, wrap-up.
	initial begin
		result_t no_result;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		func     <= FUNC_GET_VALUE;
		key      <= '0;
		value    <= '0;
		position <= '0;
		hold_off_req    = 1'b0;
		send_idle_pct   = 34;
		recv_idle_pct   = 72;
		error_count     = 0;
		results_checked = 0;
		full_results    = 0;
		miss_results    = 0;
		cycle_count     = 0;
		list_len        = 0;
		peak_len        = 0;
		no_result       = '{default: '0};
		foreach (stored_value[i]) stored_value[i] = '0;
		foreach (sorted_keys[i]) sorted_keys[i] = '0;
		foreach (func_seen[i]) func_seen[i] = 0;

		// Empty list, fresh value store, invalid codes.
		add_row(FUNC_GET_VALUE, 8'd0, 0, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_GET_VALUE, 8'd255, 0, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_FIND_POS, 8'd5, 0, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_KEY_AT_POS, 8'd0, 0, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_UPDATE, 8'd7, 123, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_GET_VALUE, 8'd7, 0, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_RESERVED_6, 8'd9, 99, 6'd3, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_RESERVED_7, 8'd9, 99, 6'd3, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		// Inserts at the value extremes, ties and an append to the tail.
		add_row(FUNC_INSERT, 8'd10, VALUE_MAX, 6'd0, 1, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_INSERT, 8'd255, VALUE_MIN, 6'd0, 1, 6'd1, 8'd0, 0, STATUS_OK);
		add_row(FUNC_INSERT, 8'd0, 0, 6'd0, 1, 6'd1, 8'd0, 0, STATUS_OK);
		add_row(FUNC_INSERT, 8'd20, 0, 6'd0, 1, 6'd1, 8'd0, 0, STATUS_OK);
		add_row(FUNC_APPEND, 8'd30, VALUE_MAX, 6'd0, 1, 6'd4, 8'd0, 0, STATUS_OK);
		add_row(FUNC_KEY_AT_POS, 8'd0, 0, 6'd63, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_KEY_AT_POS, 8'd0, 0, 6'd4, 1, 6'd0, 8'd30, 0, STATUS_OK);
		// A duplicate key, then updates that reorder the list.
		add_row(FUNC_INSERT, 8'd10, 5, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_FIND_POS, 8'd10, 0, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_UPDATE, 8'd30, 32'sh0001_8000, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_UPDATE, 8'd255, VALUE_MAX, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_GET_VALUE, 8'd255, 0, 6'd0, 1, 6'd0, 8'd0, VALUE_MAX, STATUS_OK);
		add_row(FUNC_GET_VALUE, 8'd10, 0, 6'd0, 1, 6'd0, 8'd0, 5, STATUS_OK);
		add_row(FUNC_FIND_POS, 8'd0, 0, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_KEY_AT_POS, 8'd0, 0, 6'd21, 1, 6'd0, 8'd0, 0, STATUS_MISS);
		add_row(FUNC_UPDATE, 8'd20, 32'shFFFF_0000, 6'd0, 0, 6'd0, 8'd0, 0, STATUS_OK);
		add_row(FUNC_GET_VALUE, 8'd99, VALUE_MIN, 6'd63, 1, 6'd0, 8'd0, 0, STATUS_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		drain_results();

		// Random phases: receiver-heavy idling, sender-heavy idling, then none but one receiver hold-off.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_off_req  = 1'b1;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				offer_request(random_request(), 0, no_result);
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent: get %0d, ins %0d, app %0d, upd %0d, find %0d, at %0d, bad %0d",
			func_seen[FUNC_GET_VALUE], func_seen[FUNC_INSERT], func_seen[FUNC_APPEND],
			func_seen[FUNC_UPDATE], func_seen[FUNC_FIND_POS], func_seen[FUNC_KEY_AT_POS],
			func_seen[FUNC_RESERVED_6] + func_seen[FUNC_RESERVED_7]);
		$display("Checked %0d results, peak list %0d, full %0d, miss %0d, errors %0d",
			results_checked, peak_len, full_results, miss_results, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vskl_pkg.sv
hw/rtl/vskl_ram.sv
hw/rtl/vskl_cell.sv
hw/rtl/value_sorted_key_list.sv
tb/testbench.sv
